// ----- rtl/dlr_pkg.sv -----
// Package for the DDA line rasterizer: constants, config register indexes,
// command and result codes. No dependencies.
`default_nettype none

package dlr_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int COLOR_W        = 32;

  // configuration port
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd2160;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd1440;

  // request and result codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_STEP    = 1'b1;
  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/dlr_ifs.sv -----
// Valid/ready channel interfaces of the DDA line rasterizer.
// Depends on dlr_pkg.
`default_nettype none

interface dlr_in_if
  import dlr_pkg::*;
#(
  parameter int CW = COORD_BITS_DEF
);
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [CW-1:0]      x_start;
  logic [CW-1:0]      y_start;
  logic [CW-1:0]      x_end;
  logic [CW-1:0]      y_end;
  logic [COLOR_W-1:0] line_color;

  modport source (output valid, cmd, x_start, y_start, x_end, y_end, line_color,
                  input ready);
  modport sink   (input valid, cmd, x_start, y_start, x_end, y_end, line_color,
                  output ready);
endinterface

interface dlr_out_if
  import dlr_pkg::*;
#(
  parameter int CW = COORD_BITS_DEF
);
  logic               valid;
  logic               ready;
  logic               kind;
  logic [CW-1:0]      pixel_x;
  logic [CW-1:0]      pixel_y;
  logic [COLOR_W-1:0] pixel_color;
  logic               last;

  modport source (output valid, kind, pixel_x, pixel_y, pixel_color, last,
                  input ready);
  modport sink   (input valid, kind, pixel_x, pixel_y, pixel_color, last,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/dlr_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on dlr_pkg.
`default_nettype none

module dlr_div
  import dlr_pkg::*;
#(
  parameter int CW = COORD_BITS_DEF,
  parameter int FW = FRAC_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [CW+FW-1:0] dividend,
  input  wire logic [CW-1:0]    divisor,
  output logic                  done,
  output logic [CW+FW-1:0]      quotient
);

  localparam int DW  = CW + FW;
  localparam int CNW = $clog2(DW + 1);

  logic [CW-1:0]  rem_r, rem_nxt;
  logic [DW-1:0]  quo_r, quo_nxt;
  logic [CW-1:0]  dvs_r, dvs_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;

  logic [CW:0] shifted;
  logic [CW:0] trial;
  logic        fits;

  always_comb begin
    shifted = {rem_r, quo_r[DW-1]};
    trial   = shifted - {1'b0, dvs_r};
    fits    = shifted >= {1'b0, dvs_r};

    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = CNW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? trial[CW-1:0] : shifted[CW-1:0];
      quo_nxt = {quo_r[DW-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- rtl/dda_line_rasterizer_unit.sv -----
// Top level of the DDA line rasterizer: load setup, step sequencer, output stage.
// Depends on dlr_pkg, dlr_ifs (dlr_in_if, dlr_out_if) and dlr_div.
//
//   port      dir   handshake    carries
//   in_ch     in    valid/ready  cmd, x_start, y_start, x_end, y_end, line_color
//   out_ch    out   valid/ready  kind, pixel_x, pixel_y, pixel_color, last
//   cfg_*     in    write only   frame_width (index 0), frame_height (index 1)
//
// A step request yields one pixel while the line has pixels left, one per clock
// while out_ch drains. A load of a non-empty line runs two divisions on the shared
// divider, x then y; in_ch is not ready during that time. Rejected and zero-length
// loads do not use the divider. Reset is synchronous and clears the line in
// progress; out_ch stalls hold the output register and block in_ch.
`default_nettype none

module dda_line_rasterizer_unit
  import dlr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  dlr_in_if.sink                    in_ch,
  dlr_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int CW    = COORD_BITS;
  localparam int FW    = FRAC_BITS;
  localparam int AW    = CW + FW + 1;
  localparam int DW    = CW + FW;
  localparam int QW    = FW + 1;
  localparam int SW    = FW + 2;
  localparam int CMP_W = (CW > CFG_W) ? CW : CFG_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIVX = 2'd1;
  localparam logic [1:0] ST_DIVY = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [CFG_W-1:0]   fw_r, fw_nxt;
  logic [CFG_W-1:0]   fh_r, fh_nxt;
  logic [AW-1:0]      pos_x_r, pos_x_nxt;
  logic [AW-1:0]      pos_y_r, pos_y_nxt;
  logic [SW-1:0]      step_x_r, step_x_nxt;
  logic [SW-1:0]      step_y_r, step_y_nxt;
  logic [CW-1:0]      left_r, left_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic [CW-1:0]      ady_r, ady_nxt;
  logic               dy_neg_r, dy_neg_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_kind_r, out_kind_nxt;
  logic [CW-1:0]      out_x_r, out_x_nxt;
  logic [CW-1:0]      out_y_r, out_y_nxt;
  logic [COLOR_W-1:0] out_color_r, out_color_nxt;
  logic               out_last_r, out_last_nxt;

  logic          in_fire;
  logic          reject;
  logic [CW-1:0] xs, ys, xe, ye;
  logic [CW-1:0] adx;
  logic [CW:0]   dy;
  logic [CW-1:0] ady;
  logic [CW-1:0] n_load;
  logic [AW-1:0] rnd_x, rnd_y;
  logic [QW-1:0] q;

  logic          div_start;
  logic [DW-1:0] div_dividend;
  logic [CW-1:0] div_divisor;
  logic          div_done;
  logic [DW-1:0] div_quotient;

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // endpoint check, ordering by x, deltas and pixel count
  always_comb begin
    reject = (CMP_W'(in_ch.x_start) >= CMP_W'(fw_r)) ||
             (CMP_W'(in_ch.x_end)   >= CMP_W'(fw_r)) ||
             (CMP_W'(in_ch.y_start) >= CMP_W'(fh_r)) ||
             (CMP_W'(in_ch.y_end)   >= CMP_W'(fh_r));
    if (in_ch.x_start > in_ch.x_end) begin
      xs = in_ch.x_end;
      ys = in_ch.y_end;
      xe = in_ch.x_start;
      ye = in_ch.y_start;
    end else begin
      xs = in_ch.x_start;
      ys = in_ch.y_start;
      xe = in_ch.x_end;
      ye = in_ch.y_end;
    end
    adx    = xe - xs;
    dy     = {1'b0, ye} - {1'b0, ys};
    ady    = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    n_load = (adx >= ady) ? adx : ady;
  end

  assign div_start    = (in_fire && in_ch.cmd == CMD_LOAD && !reject && n_load != '0) ||
                        (state_r == ST_DIVX && div_done);
  assign div_dividend = (state_r == ST_IDLE) ? {adx, {FW{1'b0}}} : {ady_r, {FW{1'b0}}};
  assign div_divisor  = (state_r == ST_IDLE) ? n_load : n_r;
  assign q            = div_quotient[QW-1:0];

  dlr_div #(
    .CW (CW),
    .FW (FW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign rnd_x = pos_x_r + AW'(1 << (FW - 1));
  assign rnd_y = pos_y_r + AW'(1 << (FW - 1));

  always_comb begin
    state_nxt  = state_r;
    fw_nxt     = fw_r;
    fh_nxt     = fh_r;
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    step_x_nxt = step_x_r;
    step_y_nxt = step_y_r;
    left_nxt   = left_r;
    n_nxt      = n_r;
    ady_nxt    = ady_r;
    dy_neg_nxt = dy_neg_r;
    color_nxt  = color_r;

    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_color_nxt = out_color_r;
    out_last_nxt  = out_last_r;

    if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  fw_nxt = cfg_wdata;
        REG_FRAME_HEIGHT: fh_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_ch.cmd == CMD_LOAD) begin
          left_nxt = '0;
          if (reject) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_REJECT;
            out_x_nxt     = '0;
            out_y_nxt     = '0;
            out_color_nxt = '0;
            out_last_nxt  = 1'b0;
          end else begin
            color_nxt  = in_ch.line_color;
            pos_x_nxt  = {1'b0, xs, {FW{1'b0}}};
            pos_y_nxt  = {1'b0, ys, {FW{1'b0}}};
            n_nxt      = n_load;
            ady_nxt    = ady;
            dy_neg_nxt = dy[CW];
            step_x_nxt = '0;
            step_y_nxt = '0;
            if (n_load != '0) begin
              state_nxt = ST_DIVX;
            end
          end
        end else if (in_fire && left_r != '0) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_PIXEL;
          out_x_nxt     = rnd_x[FW+CW-1:FW];
          out_y_nxt     = rnd_y[FW+CW-1:FW];
          out_color_nxt = color_r;
          out_last_nxt  = (left_r == CW'(1));
          pos_x_nxt     = pos_x_r + {{(AW-SW){step_x_r[SW-1]}}, step_x_r};
          pos_y_nxt     = pos_y_r + {{(AW-SW){step_y_r[SW-1]}}, step_y_r};
          left_nxt      = left_r - 1'b1;
        end
      end
      ST_DIVX: begin
        if (div_done) begin
          step_x_nxt = {1'b0, q};
          state_nxt  = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (div_done) begin
          step_y_nxt = dy_neg_r ? SW'(-{1'b0, q}) : {1'b0, q};
          left_nxt   = n_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fw_r        <= FRAME_WIDTH_RST;
      fh_r        <= FRAME_HEIGHT_RST;
      left_r      <= '0;
      out_valid_r <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      step_x_r    <= '0;
      step_y_r    <= '0;
      color_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      fw_r        <= fw_nxt;
      fh_r        <= fh_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      step_x_r    <= step_x_nxt;
      step_y_r    <= step_y_nxt;
      color_r     <= color_nxt;
    end
    n_r         <= n_nxt;
    ady_r       <= ady_nxt;
    dy_neg_r    <= dy_neg_nxt;
    out_kind_r  <= out_kind_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_color_r <= out_color_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_kind_r;
  assign out_ch.pixel_x     = out_x_r;
  assign out_ch.pixel_y     = out_y_r;
  assign out_ch.pixel_color = out_color_r;
  assign out_ch.last        = out_last_r;

endmodule

`default_nettype wire

// ----- sim/dda_line_rasterizer_unit_test.sv -----
// Testbench for dda_line_rasterizer_unit: directed and random line requests,
// checked pixel by pixel against a fixed-point DDA predictor.
// Depends on dlr_pkg, dlr_ifs and the rasterizer RTL.
`default_nettype none

module dda_line_rasterizer_unit_test;
  import dlr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = COORD_BITS_DEF;
  localparam int FW = FRAC_BITS_DEF;
  localparam int AW = CW + FW + 1;
  localparam int COORD_MAX = (1 << CW) - 1;
  // room for the two divisions of a load, plus margin
  localparam int SETTLE_CYCLES = 2 * (CW + FW + 1) + 20;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_IDLE = 18;

  typedef struct packed {
    logic               cmd;
    logic [CW-1:0]      x_start;
    logic [CW-1:0]      y_start;
    logic [CW-1:0]      x_end;
    logic [CW-1:0]      y_end;
    logic [COLOR_W-1:0] line_color;
  } line_req_t;

  typedef struct packed {
    logic               kind;
    logic [CW-1:0]      pixel_x;
    logic [CW-1:0]      pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last;
  } pixel_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  dlr_in_if  #(.CW(CW)) in_ch ();
  dlr_out_if #(.CW(CW)) out_ch ();

  dda_line_rasterizer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [CFG_W-1:0]   frame_w;
  logic [CFG_W-1:0]   frame_h;
  logic [AW-1:0]      acc_x;
  logic [AW-1:0]      acc_y;
  logic [AW-1:0]      inc_x;
  logic [AW-1:0]      inc_y;
  logic [CFG_W-1:0]   remaining;
  logic [COLOR_W-1:0] line_color_q;

  pixel_t      pending_pixels[$];
  int          failures;
  int          requests_sent;
  int          results_seen;
  int          results_paced;
  int          stall_left;
  int          cycle_count;
  bit          tx_gaps_on;
  bit          rx_gaps_on;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int line_length(input logic [CW-1:0] xs, input logic [CW-1:0] ys,
                                     input logic [CW-1:0] xe, input logic [CW-1:0] ye);
    int dx, dy;
    dx = int'(xe) - int'(xs);
    dy = int'(ye) - int'(ys);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return (dx >= dy) ? dx : dy;
  endfunction

  // (delta << FW) / count, truncated toward zero, as two's complement
  function automatic logic [AW-1:0] axis_increment(input int delta, input int count);
    longint mag, q;
    mag = (delta < 0) ? -delta : delta;
    q = (mag << FW) / count;
    return (delta < 0) ? AW'(-q) : AW'(q);
  endfunction

  function automatic bit rasterize_request(input line_req_t rq, output pixel_t px);
    logic [CW-1:0] x0, y0, x1, y1, t;
    logic [AW-1:0] rx, ry;
    int len;
    px = '0;
    if (rq.cmd == CMD_LOAD) begin
      if (rq.x_start >= frame_w || rq.x_end >= frame_w ||
          rq.y_start >= frame_h || rq.y_end >= frame_h) begin
        remaining = '0;
        px.kind = KIND_REJECT;
        return 1'b1;
      end
      x0 = rq.x_start;
      y0 = rq.y_start;
      x1 = rq.x_end;
      y1 = rq.y_end;
      if (x0 > x1) begin
        t = x0; x0 = x1; x1 = t;
        t = y0; y0 = y1; y1 = t;
      end
      len = line_length(x0, y0, x1, y1);
      line_color_q = rq.line_color;
      acc_x = {1'b0, x0, {FW{1'b0}}};
      acc_y = {1'b0, y0, {FW{1'b0}}};
      if (len == 0) begin
        inc_x = '0;
        inc_y = '0;
        remaining = '0;
      end else begin
        inc_x = axis_increment(int'(x1) - int'(x0), len);
        inc_y = axis_increment(int'(y1) - int'(y0), len);
        remaining = CFG_W'(len);
      end
      return 1'b0;
    end
    if (remaining == 0) return 1'b0;
    rx = acc_x + (AW'(1) << (FW - 1));
    ry = acc_y + (AW'(1) << (FW - 1));
    px.kind        = KIND_PIXEL;
    px.pixel_x     = rx[CW+FW-1:FW];
    px.pixel_y     = ry[CW+FW-1:FW];
    px.pixel_color = line_color_q;
    px.last        = (remaining == 1);
    acc_x = acc_x + inc_x;
    acc_y = acc_y + inc_y;
    remaining = remaining - 1'b1;
    return 1'b1;
  endfunction

  // result checker
  always @(posedge clk) begin : check_result
    pixel_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen = results_seen + 1;
      if (pending_pixels.size() == 0) begin
        $error("unexpected result: kind %0d x %0d y %0d color %08h last %0d",
               out_ch.kind, out_ch.pixel_x, out_ch.pixel_y, out_ch.pixel_color, out_ch.last);
        failures = failures + 1;
      end else begin
        want = pending_pixels.pop_front();
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
          failures = failures + 1;
        end
        if (out_ch.pixel_x !== want.pixel_x) begin
          $error("pixel_x: expected %0d, got %0d", want.pixel_x, out_ch.pixel_x);
          failures = failures + 1;
        end
        if (out_ch.pixel_y !== want.pixel_y) begin
          $error("pixel_y: expected %0d, got %0d", want.pixel_y, out_ch.pixel_y);
          failures = failures + 1;
        end
        if (out_ch.pixel_color !== want.pixel_color) begin
          $error("pixel_color: expected %08h, got %08h", want.pixel_color, out_ch.pixel_color);
          failures = failures + 1;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_ch.last);
          failures = failures + 1;
        end
      end
    end
  end

  // output backpressure: a fresh stall is drawn after every accepted result
  always @(negedge clk) begin : pace_output
    int wait_n;
    wait_n = stall_left;
    if (results_seen != results_paced) begin
      results_paced = results_seen;
      wait_n = rx_gaps_on ? int'($urandom_range(0, MAX_IDLE)) : 0;
    end
    if (wait_n != 0) begin
      out_ch.ready <= 1'b0;
      stall_left = wait_n - 1;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left = 0;
    end
  end

  task automatic send_request(input logic cmd, input logic [CW-1:0] xs,
                              input logic [CW-1:0] ys, input logic [CW-1:0] xe,
                              input logic [CW-1:0] ye, input logic [COLOR_W-1:0] color);
    int gap;
    line_req_t rq;
    pixel_t px;
    gap = tx_gaps_on ? int'($urandom_range(0, MAX_IDLE)) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.x_start    <= xs;
    in_ch.y_start    <= ys;
    in_ch.x_end      <= xe;
    in_ch.y_end      <= ye;
    in_ch.line_color <= color;
    do @(posedge clk); while (!in_ch.ready);
    rq = '{cmd, xs, ys, xe, ye, color};
    if (rasterize_request(rq, px)) pending_pixels.push_back(px);
    requests_sent = requests_sent + 1;
  endtask

  task automatic step_once();
    send_request(CMD_STEP, CW'($urandom()), CW'($urandom()), CW'($urandom()),
                 CW'($urandom()), $urandom());
  endtask

  task automatic step_pixels(input int n);
    repeat (n) step_once();
  endtask

  // lower valid, let every expected pixel arrive, then let a running division finish
  task automatic drain_pipeline();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    drain_pipeline();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FRAME_WIDTH) frame_w = value;
    else frame_h = value;
  endtask

  function automatic logic [CW-1:0] nearby_coord(input int base, input int span, input int lim);
    int v;
    v = base - span + int'($urandom_range(0, 2 * span));
    if (v < 0) v = 0;
    if (v > lim) v = lim;
    return CW'(v);
  endfunction

  // mostly whole lines stepped to the end, plus stray steps and wild loads
  task automatic run_random_lines(input int n_items, input int w_lim, input int h_lim);
    int stop_at, next_shuffle, pick, span, len, steps;
    logic [CW-1:0] xs, ys, xe, ye;
    stop_at = requests_sent + n_items;
    next_shuffle = requests_sent;
    while (requests_sent < stop_at) begin
      if (requests_sent >= next_shuffle) begin
        tx_gaps_on = ($urandom_range(0, 3) != 0);
        rx_gaps_on = ($urandom_range(0, 3) != 0);
        next_shuffle = requests_sent + int'($urandom_range(40, 160));
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        step_once();
      end else if (pick < 20) begin
        send_request(CMD_LOAD, CW'($urandom()), CW'($urandom()), CW'($urandom()),
                     CW'($urandom()), $urandom());
        step_pixels($urandom_range(0, 3));
      end else begin
        xs = CW'($urandom_range(0, w_lim));
        ys = CW'($urandom_range(0, h_lim));
        span = ($urandom_range(0, 15) == 0) ? COORD_MAX : int'($urandom_range(0, 24));
        xe = nearby_coord(xs, span, w_lim);
        ye = nearby_coord(ys, span, h_lim);
        send_request(CMD_LOAD, xs, ys, xe, ye, $urandom());
        len = line_length(xs, ys, xe, ye);
        if (len > 80) steps = $urandom_range(1, 12);
        else if ($urandom_range(0, 4) == 0) steps = $urandom_range(0, len);
        else steps = len + int'($urandom_range(0, 2));
        step_pixels(steps);
      end
    end
  endtask

  task automatic test_directed();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    step_once();                                        // nothing loaded yet
    send_request(CMD_LOAD, 0, 0, 4, 2, 32'hFFFF_FFFF);
    step_pixels(5);                                     // one step past the end
    send_request(CMD_LOAD, 10, 3, 2, 9, 32'h1234_5678); // swapped endpoints
    step_pixels(3);
    send_request(CMD_LOAD, 5, 20, 6, 10, 32'h0000_0000); // steep, y falling, replaces line
    step_pixels(2);
    send_request(CMD_LOAD, 7, 7, 7, 7, 32'hA5A5_A5A5);  // zero length
    step_once();
    send_request(CMD_LOAD, 2159, 0, 2160, 0, 32'h5A5A_5A5A); // x_end just outside
    step_once();
    send_request(CMD_LOAD, 2158, 1439, 2159, 1438, 32'hDEAD_BEEF);
    step_pixels(2);
  endtask

  task automatic test_large_frame();
    write_frame(REG_FRAME_WIDTH, {CFG_W{1'b1}});
    write_frame(REG_FRAME_HEIGHT, CFG_W'(1 << CW));
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    send_request(CMD_LOAD, CW'(COORD_MAX), 0, 0, CW'(COORD_MAX), 32'hFFFF_FFFF);
    step_pixels(3);
    send_request(CMD_LOAD, 0, CW'(COORD_MAX), CW'(COORD_MAX), CW'(COORD_MAX), 32'h0);
    step_pixels(2);
    send_request(CMD_LOAD, CW'(COORD_MAX), CW'(COORD_MAX), CW'(COORD_MAX), 0, 32'h8000_0001);
    step_pixels(2);
    run_random_lines(700, COORD_MAX, COORD_MAX);
  endtask

  task automatic test_tiny_frame();
    write_frame(REG_FRAME_WIDTH, '0);
    send_request(CMD_LOAD, 0, 0, 1, 1, 32'h1111_1111); // zero width rejects all
    step_once();
    write_frame(REG_FRAME_WIDTH, 13'd1);
    write_frame(REG_FRAME_HEIGHT, '0);
    send_request(CMD_LOAD, 0, 0, 0, 0, 32'h2222_2222); // zero height rejects all
    write_frame(REG_FRAME_HEIGHT, 13'd1);
    send_request(CMD_LOAD, 0, 0, 0, 0, 32'h3333_3333);
    step_once();
    send_request(CMD_LOAD, 0, 0, 0, 1, 32'h4444_4444);
  endtask

  task automatic test_small_frame();
    write_frame(REG_FRAME_WIDTH, 13'd40);
    write_frame(REG_FRAME_HEIGHT, 13'd30);
    // endpoints range a little past the frame so rejects land mid-line
    run_random_lines(350, 47, 37);
  endtask

  task automatic test_default_frame();
    write_frame(REG_FRAME_WIDTH, FRAME_WIDTH_RST);
    write_frame(REG_FRAME_HEIGHT, FRAME_HEIGHT_RST);
    run_random_lines(400, COORD_MAX, COORD_MAX);
    drain_pipeline();  // sender holds off until drained
    run_random_lines(450, 2159, 1439);
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_FRAME_WIDTH;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_LOAD;
    in_ch.x_start    = '0;
    in_ch.y_start    = '0;
    in_ch.x_end      = '0;
    in_ch.y_end      = '0;
    in_ch.line_color = '0;
    out_ch.ready     = 1'b0;
    frame_w          = FRAME_WIDTH_RST;
    frame_h          = FRAME_HEIGHT_RST;
    acc_x            = '0;
    acc_y            = '0;
    inc_x            = '0;
    inc_y            = '0;
    remaining        = '0;
    line_color_q     = '0;
    failures         = 0;
    requests_sent    = 0;
    results_seen     = 0;
    results_paced    = 0;
    stall_left       = 0;
    cycle_count      = 0;
    tx_gaps_on       = 1'b1;
    rx_gaps_on       = 1'b1;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_large_frame();
    test_tiny_frame();
    test_small_frame();
    test_default_frame();
    drain_pipeline();

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/dlr_pkg.sv
rtl/dlr_ifs.sv
rtl/dlr_div.sv
rtl/dda_line_rasterizer_unit.sv
sim/dda_line_rasterizer_unit_test.sv
